// File: design/html_entity_decoder_macros.svh
// Assertion macros used by the checker file of the entity decoder.
`ifndef HTML_ENTITY_DECODER_MACROS_SVH
`define HTML_ENTITY_DECODER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define HED_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication that stays live through reset.
`define HED_ASSERT_AFTER(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/hed_pkg.sv
// Types, constants and entity tables of the HTML entity decoder.
`default_nettype none
package hed_pkg;

   localparam int NUM_ENT     = 7;
   localparam int BODY_LEN    = 5;
   localparam int HOLD_N      = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] AMP_CHAR = 8'h26;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // One step's output: optional literal replay ('&' plus lit_n held bytes),
   // then an optional tail byte.
   typedef struct packed {
      logic                   flush;
      logic [2:0]             lit_n;
      logic [HOLD_N-1:0][7:0] lit;
      logic                   tail_v;
      logic [7:0]             tail;
      logic                   last;
   } hed_entry_type;

   // Entity bodies (text after the ampersand), lengths and replacements.
   localparam logic [7:0] ENT_BODY [NUM_ENT][BODY_LEN] = '{
      '{"a", "m", "p", ";", 8'h00},
      '{"l", "t", ";", 8'h00, 8'h00},
      '{"g", "t", ";", 8'h00, 8'h00},
      '{"q", "u", "o", "t", ";"},
      '{"#", "3", "9", ";", 8'h00},
      '{"#", "x", "2", "7", ";"},
      '{"n", "b", "s", "p", ";"}
   };

   localparam logic [2:0] ENT_LEN [NUM_ENT] = '{
      3'd4, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5, 3'd5
   };

   localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{
      8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h27, 8'h20
   };

endpackage
`default_nettype wire

// File: design/html_entity_decoder.sv
// Top level of the streaming HTML entity decoder.
//
//   channel   dir   handshake          payload
//   req       in    req_push/req_full  req_data  (in_byte, in_last)
//   rsp       out   rsp_pop/rsp_empty  rsp_data  (out_byte, out_last)
//
// One text byte is taken per cycle while req_full is low; its results pass through a queue
// slot and then the back end's result register before they show on the result ports.
// A literal replay entry (the ampersand, up to four held bytes and a tail byte) drains at
// one byte per cycle while results are popped; req_full rises once both queue entries wait.
// Synchronous active-high reset clears the match state, queue and result valid flag.
// Stalls on either side hold their data; front and back stall independently.
`default_nettype none
module html_entity_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  hed_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output hed_pkg::rsp_type rsp_data
);
   import hed_pkg::*;

   logic          q_push, q_full, q_valid, q_pop;
   hed_entry_type q_in, q_head;

   hed_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_entry  (q_in),
      .q_full   (q_full)
   );

   hed_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .valid      (q_valid),
      .pop        (q_pop),
      .head       (q_head)
   );

   hed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: design/hed_front.sv
// Front end: accepts text bytes, tracks entity matches, builds output entries.
`default_nettype none
module hed_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  hed_pkg::req_type       req_data,
   output logic                   q_push,
   output hed_pkg::hed_entry_type q_entry,
   input  logic                   q_full
);
   import hed_pkg::*;

   logic                   amp_ff, amp_in;
   logic [2:0]             count_ff, count_in;
   logic [NUM_ENT-1:0]     mask_ff, mask_in;
   logic [HOLD_N-1:0][7:0] held_ff, held_in;

   logic                   accept;
   logic [7:0]             c;
   logic [2:0]             next_n;
   logic [NUM_ENT-1:0]     match;
   logic                   complete, prefix, fresh;
   logic [7:0]             hit_char;
   logic [HOLD_N-1:0][7:0] lit_app;
   hed_entry_type          e;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign c        = req_data.in_byte;
   assign next_n   = count_ff + 3'd1;

   // Candidate entities still matching after this byte
   always_comb begin
      complete = 1'b0;
      prefix   = 1'b0;
      hit_char = '0;
      for (int i = 0; i < NUM_ENT; i++) begin
         match[i] = mask_ff[i] && (count_ff < ENT_LEN[i]) &&
                    (ENT_BODY[i][count_ff] == c);
         if (match[i] && (ENT_LEN[i] == next_n)) begin
            complete = 1'b1;
            hit_char = ENT_CHAR[i];
         end
         if (match[i] && (ENT_LEN[i] > next_n)) begin
            prefix = 1'b1;
         end
      end
      for (int j = 0; j < HOLD_N; j++) begin
         lit_app[j] = (3'(j) == count_ff) ? c : held_ff[j];
      end
   end

   // Step decision: entity hit, longer prefix, divergence, new ampersand or plain byte
   always_comb begin
      e        = '0;
      e.last   = req_data.in_last;
      amp_in   = amp_ff;
      count_in = count_ff;
      mask_in  = mask_ff;
      held_in  = held_ff;
      fresh    = 1'b1;
      if (amp_ff) begin
         if (complete) begin
            e.tail_v = 1'b1;
            e.tail   = hit_char;
            amp_in   = 1'b0;
            count_in = '0;
            fresh    = 1'b0;
         end else if (prefix) begin
            held_in[count_ff[1:0]] = c;
            count_in = next_n;
            mask_in  = match;
            fresh    = 1'b0;
            if (req_data.in_last) begin
               e.flush  = 1'b1;
               e.lit    = lit_app;
               e.lit_n  = next_n;
               amp_in   = 1'b0;
               count_in = '0;
            end
         end else begin
            e.flush  = 1'b1;
            e.lit    = held_ff;
            e.lit_n  = count_ff;
            amp_in   = 1'b0;
            count_in = '0;
         end
      end
      if (fresh) begin
         if (c == AMP_CHAR) begin
            amp_in   = 1'b1;
            count_in = '0;
            mask_in  = '1;
            if (req_data.in_last) begin
               e.tail_v = 1'b1;
               e.tail   = AMP_CHAR;
               amp_in   = 1'b0;
            end
         end else begin
            e.tail_v = 1'b1;
            e.tail   = c;
         end
      end
   end

   assign q_push  = accept && (e.flush || e.tail_v);
   assign q_entry = e;

   // Match state
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff   <= 1'b0;
         count_ff <= '0;
         mask_ff  <= '0;
      end else if (accept) begin
         amp_ff   <= amp_in;
         count_ff <= count_in;
         mask_ff  <= mask_in;
      end
   end

   // Held bytes, payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule
`default_nettype wire

// File: design/hed_queue.sv
// Short queue of output entries between front and back ends.
`default_nettype none
module hed_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hed_pkg::hed_entry_type push_entry,
   output logic                   full,
   output logic                   valid,
   input  logic                   pop,
   output hed_pkg::hed_entry_type head
);
   import hed_pkg::*;

   hed_entry_type    slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// File: design/hed_back.sv
// Back end: walks each entry byte by byte into the result register.
`default_nettype none
module hed_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  hed_pkg::hed_entry_type q_entry,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output hed_pkg::rsp_type       rsp_data
);
   import hed_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic [2:0] total;
   logic       is_end, load;
   logic [1:0] lit_idx;
   logic [7:0] sel_byte;

   assign total   = {2'b00, q_entry.flush} + q_entry.lit_n + {2'b00, q_entry.tail_v};
   assign is_end  = (idx_ff == total - 3'd1);
   assign load    = q_valid && (!out_valid_ff || rsp_pop);
   assign q_pop   = load && is_end;
   assign lit_idx = 2'(idx_ff - 3'd1);

   // Byte at the current position of the head entry
   always_comb begin
      if (q_entry.flush && (idx_ff == 3'd0)) begin
         sel_byte = AMP_CHAR;
      end else if (q_entry.flush && (idx_ff <= q_entry.lit_n)) begin
         sel_byte = q_entry.lit[lit_idx];
      end else begin
         sel_byte = q_entry.tail;
      end
   end

   // Position and result register control
   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = is_end ? 3'd0 : idx_ff + 3'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff.out_byte <= sel_byte;
         out_ff.out_last <= q_entry.last && is_end;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

// File: design/hed_checker.sv
// Port-level checks for the entity decoder and their bind to the top level.
`default_nettype none
module hed_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input hed_pkg::req_type req_data,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input hed_pkg::rsp_type rsp_data
);
   `include "html_entity_decoder_macros.svh"

   // Nothing waits on the result side right after reset
   `HED_ASSERT_AFTER(a_reset_empty, clock, reset, rsp_empty, "result pending after reset")

   // A waiting result that is not taken stays put
   `HED_ASSERT_IMPLIES(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, ##1 (!rsp_empty && $stable(rsp_data)), "stalled result changed")

   // An accepted 8'h5A byte, outside every entity, always leads to a waiting result
   `HED_ASSERT_IMPLIES(a_plain_latency, clock, reset, req_push && !req_full && req_data.in_byte == 8'h5A, ##2 !rsp_empty, "plain byte produced no result")

endmodule

bind html_entity_decoder hed_checker u_checker (.*);
`default_nettype wire

// File: sim/entity_decode_checker.sv
// Scoreboard for the entity decoder: predicts decoded bytes and checks every response.
`timescale 1ns / 1ps
module entity_decode_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  hed_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  hed_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import hed_pkg::*;

   // Reference kinds, in match priority order
   typedef enum int {
      REF_AMP, REF_LT, REF_GT, REF_QUOT, REF_DEC_APOS, REF_HEX_APOS, REF_NBSP, REF_COUNT
   } ref_kind_type;

   localparam int PREFIX_HIT = -1;
   localparam int NO_HIT     = -2;
   localparam int HOLD_MAX   = 5;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Predictor state
   logic       amp_held;
   logic [7:0] held_text [0:HOLD_MAX-1];
   int         held_cnt;
   rsp_type    decoded_bytes [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      amp_held   = 1'b0;
      held_cnt   = 0;
   end

   // Text after the ampersand for each reference
   function automatic string ref_body(int k);
      case (k)
         REF_AMP:      return "amp;";
         REF_LT:       return "lt;";
         REF_GT:       return "gt;";
         REF_QUOT:     return "quot;";
         REF_DEC_APOS: return "#39;";
         REF_HEX_APOS: return "#x27;";
         REF_NBSP:     return "nbsp;";
         default:      return "";
      endcase
   endfunction

   function automatic logic [7:0] ref_char(int k);
      case (k)
         REF_AMP:      return CH_AMP;
         REF_LT:       return CH_LT;
         REF_GT:       return CH_GT;
         REF_QUOT:     return CH_QUOT;
         REF_DEC_APOS: return CH_APOS;
         REF_HEX_APOS: return CH_APOS;
         default:      return CH_SPACE;
      endcase
   endfunction

   // Held bytes plus c: full reference index, proper prefix, or no match
   function automatic int match_ref(logic [7:0] c);
      logic [7:0] cand [0:HOLD_MAX-1];
      string      body;
      int         n;
      bit         same;
      bit         prefix;
      if (held_cnt >= HOLD_MAX)
         return NO_HIT;
      for (int i = 0; i < held_cnt; i++)
         cand[i] = held_text[i];
      cand[held_cnt] = c;
      n      = held_cnt + 1;
      prefix = 1'b0;
      for (int k = 0; k < REF_COUNT; k++) begin
         body = ref_body(k);
         if (n <= body.len()) begin
            same = 1'b1;
            for (int i = 0; i < n; i++)
               if (cand[i] != body[i])
                  same = 1'b0;
            if (same) begin
               if (n == body.len())
                  return k;
               prefix = 1'b1;
            end
         end
      end
      return prefix ? PREFIX_HIT : NO_HIT;
   endfunction

   function automatic void put_decoded(logic [7:0] b);
      rsp_type t;
      t.out_byte = b;
      t.out_last = 1'b0;
      decoded_bytes.insert(decoded_bytes.size(), t);
   endfunction

   // Replay the ampersand and held bytes literally, then drop the hold
   function automatic void replay_held();
      if (!amp_held)
         return;
      put_decoded(CH_AMP);
      for (int i = 0; i < held_cnt && i < HOLD_MAX; i++)
         put_decoded(held_text[i]);
      amp_held = 1'b0;
      held_cnt = 0;
   endfunction

   // Expected output bytes of one input transaction
   function automatic void decode_byte(req_type r);
      int      hit;
      int      start;
      bit      handled;
      start   = decoded_bytes.size();
      handled = 1'b0;
      if (amp_held) begin
         hit = match_ref(r.in_byte);
         if (hit >= 0) begin
            put_decoded(ref_char(hit));
            amp_held = 1'b0;
            held_cnt = 0;
            handled  = 1'b1;
         end else if (hit == PREFIX_HIT) begin
            held_text[held_cnt] = r.in_byte;
            held_cnt++;
            if (r.in_last)
               replay_held();
            handled = 1'b1;
         end else begin
            replay_held();
         end
      end
      if (!handled) begin
         if (r.in_byte == CH_AMP) begin
            amp_held = 1'b1;
            held_cnt = 0;
            if (r.in_last)
               replay_held();
         end else begin
            put_decoded(r.in_byte);
         end
      end
      // end of text marks only the final byte of this step
      if (r.in_last && decoded_bytes.size() > start)
         decoded_bytes[decoded_bytes.size() - 1].out_last = 1'b1;
   endfunction

   function automatic void check_byte();
      rsp_type want;
      if (decoded_bytes.size() == 0) begin
         $error("unexpected result: out_byte %h out_last %b",
                rsp_data.out_byte, rsp_data.out_last);
         fail_count++;
         return;
      end
      want = decoded_bytes.pop_front();
      if (rsp_data.out_byte !== want.out_byte) begin
         $error("out_byte: expected %h, actual %h", want.out_byte, rsp_data.out_byte);
         fail_count++;
      end
      if (rsp_data.out_last !== want.out_last) begin
         $error("out_last: expected %b, actual %b", want.out_last, rsp_data.out_last);
         fail_count++;
      end
   endfunction

   // Check responses before adding new predictions: a same-edge request is always younger
   always @(posedge clock) begin
      if (reset) begin
         amp_held = 1'b0;
         held_cnt = 0;
         decoded_bytes.delete();
      end else begin
         if (rsp_pop && !rsp_empty)
            check_byte();
         if (req_push && !req_full)
            decode_byte(req_data);
      end
      pending = decoded_bytes.size();
   end

endmodule

// File: sim/testbench.sv
// Top of the entity decoder testbench: clock, reset, text stimulus, response draining, verdict.
`timescale 1ns / 1ps
module testbench;
   import hed_pkg::*;

   localparam int RESET_CYCLES    = 11;
   localparam int RANDOM_ITEMS    = 250;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int HOLD_OFF_AT     = 40;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 20;
   localparam int MAX_GAP         = 9;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   req_type text_in [$];

   html_entity_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   entity_decode_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void add_byte(logic [7:0] b, logic last);
      req_type r;
      r.in_byte = b;
      r.in_last = last;
      text_in.insert(text_in.size(), r);
   endfunction

   function automatic void add_text(string s, bit last_at_end);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i], last_at_end && (i == s.len() - 1));
   endfunction

   // Occasional end of text inside the random stream
   function automatic logic end_mark();
      return ($urandom_range(0, 15) == 0);
   endfunction

   function automatic void build_text();
      int      k;
      int      p;
      int      target;
      // extremes, then one completed reference
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_text("&lt;", 1'b0);
      // ampersand arriving while a prefix is held
      add_text("&am&gt;", 1'b0);
      // longest hold, then a diverging byte: six results in one step
      add_text("&nbspx", 1'b0);
      // lone ampersand at end of text
      add_text("&", 1'b1);
      // end of text while a prefix is held
      add_text("&#x2", 1'b1);

      target = text_in.size() + RANDOM_ITEMS;
      while (text_in.size() < target) begin
         k = $urandom_range(0, NUM_ENT - 1);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // well-formed reference
               add_byte(AMP_CHAR, end_mark());
               for (int i = 0; i < ENT_LEN[k]; i++)
                  add_byte(ENT_BODY[k][i], end_mark());
            end
            5, 6: begin
               // broken reference: a prefix then a random byte
               p = $urandom_range(0, ENT_LEN[k] - 1);
               add_byte(AMP_CHAR, end_mark());
               for (int i = 0; i < p; i++)
                  add_byte(ENT_BODY[k][i], end_mark());
               add_byte(8'($urandom_range(0, 255)), end_mark());
            end
            7, 8: begin
               repeat ($urandom_range(1, 4))
                  add_byte(8'($urandom_range(0, 255)), end_mark());
            end
            default: begin
               add_byte(AMP_CHAR, end_mark());
            end
         endcase
      end
      text_in[text_in.size() - 1].in_last = 1'b1;
   endfunction

   // Sender and verdict
   initial begin
      int gap;
      build_text();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      for (int n = 0; n < text_in.size(); n++) begin
         gap = ((n / 50) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_data <= text_in[n];
         req_push <= 1'b1;
         do @(posedge clock); while (req_full);
         @(negedge clock);
      end
      req_push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // Receiver: random pops, one long hold-off to back up the input side
   initial begin
      int gap;
      int popped;
      popped = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = ((popped / 60) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
         if (popped == HOLD_OFF_AT)
            gap = HOLD_OFF_CYCLES;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         popped++;
         @(negedge clock);
      end
   end

   // Watchdog on cycles without any transaction
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("testbench NOT OK");
      $finish;
   end

endmodule
